// File: sv/lhq_pkg.sv
`timescale 1ns / 1ps
package lhq_pkg;

    // One table entry: a line and the x beyond which it stops being best.
    typedef struct packed {
        logic signed [31:0] slope;
        logic signed [61:0] icpt;
        logic signed [63:0] bp;
    } t_entry;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    localparam logic FN_ADD   = 1'b0;
    localparam logic FN_QUERY = 1'b1;

    localparam logic signed [63:0] BP_POS_INF = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] BP_NEG_INF = 64'sh8000_0000_0000_0001;

    localparam logic [31:0] SLOPE_MOST_NEG = 32'h8000_0000;
    localparam logic [61:0] ICPT_MOST_NEG  = {1'b1, 61'd0};

endpackage

// File: sv/lhq_in_if.sv
`timescale 1ns / 1ps
interface lhq_in_if;
    logic               valid;
    logic               ready;
    logic               func;
    logic signed [31:0] slope;
    logic signed [61:0] intercept;
    logic signed [31:0] query_point;

    modport source (output valid, func, slope, intercept, query_point, input ready);
    modport sink   (input valid, func, slope, intercept, query_point, output ready);
endinterface

// File: sv/lhq_out_if.sv
`timescale 1ns / 1ps
interface lhq_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] best_value;
    logic [1:0]         status;

    modport source (output valid, best_value, status, input ready);
    modport sink   (input valid, best_value, status, output ready);
endinterface

// File: sv/lhq_mem.sv
`timescale 1ns / 1ps
module lhq_mem #(
    parameter int DEPTH = 1024
) (
    input  logic                          i_clk,
    input  logic                          i_we,
    input  logic [$clog2(DEPTH)-1:0]      i_waddr,
    input  lhq_pkg::t_entry               i_wdata,
    input  logic [$clog2(DEPTH)-1:0]      i_raddr,
    output lhq_pkg::t_entry               o_rdata
);
    lhq_pkg::t_entry r_mem [DEPTH];
    lhq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: sv/lhq_div.sv
`timescale 1ns / 1ps
module lhq_div (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic signed [63:0] i_num,
    input  logic signed [32:0] i_den,
    output logic               o_done,
    output logic signed [63:0] o_quo
);
    // Restoring division on magnitudes, one quotient bit per cycle,
    // then floor correction when the signs differ.
    logic        r_busy;
    logic        r_fin;
    logic [5:0]  r_cnt;
    logic [63:0] r_num;
    logic [32:0] r_den;
    logic [33:0] r_rem;
    logic [63:0] r_q;
    logic        r_neg;
    logic [33:0] w_trial;
    logic        w_fit;
    logic [63:0] w_qneg;

    assign w_trial = {r_rem[32:0], r_num[63]};
    assign w_fit   = w_trial >= {1'b0, r_den};
    assign w_qneg  = (~r_q) + 64'd1 - {63'd0, (r_rem != 34'd0)};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_fin  <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_fin <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
                r_num  <= i_num[63] ? (~i_num) + 64'd1 : i_num;
                r_den  <= i_den[32] ? (~i_den) + 33'd1 : i_den;
                r_rem  <= '0;
                r_neg  <= i_num[63] ^ i_den[32];
            end else if (r_busy) begin
                r_rem <= w_fit ? w_trial - {1'b0, r_den} : w_trial;
                r_q   <= {r_q[62:0], w_fit};
                r_num <= {r_num[62:0], 1'b0};
                r_cnt <= r_cnt + 6'd1;
                if (r_cnt == 6'd63) begin
                    r_busy <= 1'b0;
                    r_fin  <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_fin;
    assign o_quo  = r_neg ? w_qneg : r_q;
endmodule

// File: sv/line_hull_min_max_query.sv
`timescale 1ns / 1ps
// Line hull min/max query. Holds up to MAX_LINES lines y = a*x + b in one
// table sorted by slope, each with the floor breakpoint where it stops being
// on the envelope. A request with func 0 adds a line (pruning the lines it
// beats), func 1 evaluates the envelope at query_point. min_mode selects the
// lower envelope. The user must keep min_mode written only while idle; the
// block itself does not enforce this. Every request gives one response:
// status 0 ok, 1 query on empty table, 2 add dropped on a full table;
// best_value is zero except for a good query. The block takes one request
// at a time over a single-port table read and a serial divider. A query
// scans the entries for the first breakpoint that reaches x, then multiplies
// and adds. An add scans for the slot, shifts the entries above it up,
// updates breakpoints and drops beaten lines; every dropped line moves the
// rest of the table down. The table needs no clearing after reset: only
// entries below the count are used.
module line_hull_min_max_query #(
    parameter int MAX_LINES = 1024
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_we,
    input  logic       i_cfg_wdata,
    lhq_in_if.sink     i_req,
    lhq_out_if.source  o_rsp
);
    localparam int AW = (MAX_LINES > 1) ? $clog2(MAX_LINES) : 1;
    localparam int CW = $clog2(MAX_LINES + 1);

    localparam logic [4:0] S_IDLE = 5'd0,  S_SCAN_RD = 5'd1,  S_SCAN_CK = 5'd2;
    localparam logic [4:0] S_SHU_RD = 5'd3, S_SHU_WR = 5'd4, S_INS = 5'd5;
    localparam logic [4:0] S_CR_START = 5'd6, S_CR_RJ = 5'd7, S_CR_LJ = 5'd8;
    localparam logic [4:0] S_CR_DIV = 5'd9, S_CR_WR = 5'd10, S_DR_RD = 5'd11;
    localparam logic [4:0] S_DR_WR = 5'd12, S_DISP = 5'd13, S_CH_RD = 5'd14;
    localparam logic [4:0] S_CH_R2 = 5'd15, S_CH_CK = 5'd16, S_Q_RD = 5'd17;
    localparam logic [4:0] S_Q_CK = 5'd18, S_Q_MUL = 5'd19, S_Q_ADD = 5'd20;
    localparam logic [4:0] S_OUT = 5'd21;

    // Where to resume after a breakpoint update or an entry drop.
    localparam logic [2:0] P_PRUNE = 3'd0, P_PRUNE_D = 3'd1, P_LEFT = 3'd2;
    localparam logic [2:0] P_LEFT_D = 3'd3, P_LEFT_X = 3'd4, P_CHAIN_D = 3'd5;
    localparam logic [2:0] P_CHAIN_X = 3'd6;

    logic [4:0]         r_state;
    logic [2:0]         r_ph;
    logic               r_min_mode;
    logic [CW-1:0]      r_cnt;
    logic [CW-1:0]      r_idx;
    logic [CW-1:0]      r_pos;
    logic [CW-1:0]      r_cur;
    logic [CW-1:0]      r_ci;
    logic [CW-1:0]      r_cj;
    logic               r_flag;
    logic               r_hj;
    logic signed [31:0] r_a;
    logic signed [61:0] r_b;
    logic signed [31:0] r_x;
    logic signed [31:0] r_ei_slope;
    logic signed [61:0] r_ei_icpt;
    logic signed [63:0] r_ej_bp;
    logic signed [63:0] r_bp;
    logic signed [63:0] r_bpa;
    logic signed [63:0] r_prod;
    logic               r_ov;
    logic signed [63:0] r_res;
    logic [1:0]         r_stat;

    logic               w_we;
    logic [AW-1:0]      w_waddr;
    lhq_pkg::t_entry    w_wdata;
    logic [AW-1:0]      w_raddr;
    lhq_pkg::t_entry    w_rdata;
    logic [CW-1:0]      w_idx_dec, w_idx_inc, w_cur_dec, w_pos_inc, w_pos_dec;
    logic signed [31:0] w_a_sat;
    logic signed [61:0] w_b_sat;
    logic               w_div_start, w_div_done;
    logic signed [63:0] w_div_num, w_div_quo;
    logic signed [32:0] w_div_den;
    logic signed [63:0] w_prod, w_sum;
    logic               w_full;

    assign w_idx_dec = r_idx - 1'b1;
    assign w_idx_inc = r_idx + 1'b1;
    assign w_cur_dec = r_cur - 1'b1;
    assign w_pos_inc = r_pos + 1'b1;
    assign w_pos_dec = r_pos - 1'b1;
    assign w_full    = r_cnt == CW'(MAX_LINES);

    // Clamp the most negative codes so negation in min mode stays in range.
    assign w_a_sat = (i_req.slope == lhq_pkg::SLOPE_MOST_NEG) ?
                     i_req.slope + 32'sd1 : i_req.slope;
    assign w_b_sat = (i_req.intercept == lhq_pkg::ICPT_MOST_NEG) ?
                     i_req.intercept + 62'sd1 : i_req.intercept;

    // Breakpoint of entry i against entry j: floor((b_j - b_i) / (a_i - a_j)).
    assign w_div_num   = {{2{w_rdata.icpt[61]}}, w_rdata.icpt} -
                         {{2{r_ei_icpt[61]}}, r_ei_icpt};
    assign w_div_den   = {r_ei_slope[31], r_ei_slope} -
                         {w_rdata.slope[31], w_rdata.slope};
    assign w_div_start = (r_state == S_CR_LJ) && (r_cj < r_cnt) &&
                         (r_ei_slope != w_rdata.slope);

    assign w_prod = r_ei_slope * r_x;
    assign w_sum  = r_prod + {{2{r_ei_icpt[61]}}, r_ei_icpt};

    lhq_mem #(.DEPTH(MAX_LINES)) u_mem (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    lhq_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_div_start),
        .i_num   (w_div_num),
        .i_den   (w_div_den),
        .o_done  (w_div_done),
        .o_quo   (w_div_quo)
    );

    // Table port addressing per sequencer step.
    always_comb begin
        w_we    = 1'b0;
        w_waddr = '0;
        w_wdata = '0;
        w_raddr = '0;
        case (r_state)
            S_SCAN_RD:  w_raddr = r_idx[AW-1:0];
            S_SHU_RD:   w_raddr = w_idx_dec[AW-1:0];
            S_SHU_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
            end
            S_INS: begin
                w_we    = 1'b1;
                w_waddr = r_pos[AW-1:0];
                w_wdata = '{slope: r_a, icpt: r_b, bp: 64'sd0};
            end
            S_CR_START: w_raddr = r_ci[AW-1:0];
            S_CR_RJ:    w_raddr = r_cj[AW-1:0];
            S_CR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_ci[AW-1:0];
                w_wdata = '{slope: r_ei_slope, icpt: r_ei_icpt, bp: r_bp};
            end
            S_DR_RD:    w_raddr = w_idx_inc[AW-1:0];
            S_DR_WR: begin
                w_we    = 1'b1;
                w_waddr = r_idx[AW-1:0];
                w_wdata = w_rdata;
            end
            S_CH_RD:    w_raddr = w_cur_dec[AW-1:0];
            S_CH_R2:    w_raddr = r_cur[AW-1:0];
            S_Q_RD:     w_raddr = r_idx[AW-1:0];
            default:    w_raddr = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_ph       <= P_PRUNE;
            r_cnt      <= '0;
            r_min_mode <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_min_mode <= i_cfg_wdata;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_req.valid) begin
                        r_a    <= r_min_mode ? -w_a_sat : w_a_sat;
                        r_b    <= r_min_mode ? -w_b_sat : w_b_sat;
                        r_x    <= i_req.query_point;
                        r_idx  <= '0;
                        r_res  <= '0;
                        if (i_req.func == lhq_pkg::FN_ADD) begin
                            if (w_full) begin
                                r_stat  <= lhq_pkg::ST_FULL;
                                r_state <= S_OUT;
                            end else begin
                                r_state <= S_SCAN_RD;
                            end
                        end else if (r_cnt == '0) begin
                            r_stat  <= lhq_pkg::ST_EMPTY;
                            r_state <= S_OUT;
                        end else begin
                            r_state <= S_Q_RD;
                        end
                    end
                end
                // Find the slot after all lines of smaller or equal slope.
                S_SCAN_RD: begin
                    if (r_idx == r_cnt) begin
                        r_pos   <= r_idx;
                        r_state <= S_SHU_RD;
                    end else begin
                        r_state <= S_SCAN_CK;
                    end
                end
                S_SCAN_CK: begin
                    if (w_rdata.slope <= r_a) begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_SCAN_RD;
                    end else begin
                        r_pos   <= r_idx;
                        r_idx   <= r_cnt;
                        r_state <= S_SHU_RD;
                    end
                end
                // Open the slot: move entries up from the top down.
                S_SHU_RD: begin
                    r_state <= (r_idx == r_pos) ? S_INS : S_SHU_WR;
                end
                S_SHU_WR: begin
                    r_idx   <= w_idx_dec;
                    r_state <= S_SHU_RD;
                end
                S_INS: begin
                    r_cnt   <= r_cnt + 1'b1;
                    r_ci    <= r_pos;
                    r_cj    <= w_pos_inc;
                    r_ph    <= P_PRUNE;
                    r_state <= S_CR_START;
                end
                // Breakpoint update of entry ci against entry cj.
                S_CR_START: r_state <= S_CR_RJ;
                S_CR_RJ: begin
                    r_ei_slope <= w_rdata.slope;
                    r_ei_icpt  <= w_rdata.icpt;
                    r_state    <= S_CR_LJ;
                end
                S_CR_LJ: begin
                    r_ej_bp <= w_rdata.bp;
                    r_hj    <= r_cj < r_cnt;
                    if (r_cj >= r_cnt) begin
                        r_bp    <= lhq_pkg::BP_POS_INF;
                        r_state <= S_CR_WR;
                    end else if (r_ei_slope == w_rdata.slope) begin
                        r_bp    <= (r_ei_icpt > w_rdata.icpt) ?
                                   lhq_pkg::BP_POS_INF : lhq_pkg::BP_NEG_INF;
                        r_state <= S_CR_WR;
                    end else begin
                        r_state <= S_CR_DIV;
                    end
                end
                S_CR_DIV: begin
                    if (w_div_done) begin
                        r_bp    <= w_div_quo;
                        r_state <= S_CR_WR;
                    end
                end
                S_CR_WR: begin
                    r_flag  <= r_hj && (r_bp >= r_ej_bp);
                    r_state <= S_DISP;
                end
                // Drop entry idx: move the entries above it down by one.
                S_DR_RD: begin
                    if (w_idx_inc >= r_cnt) begin
                        r_cnt   <= r_cnt - 1'b1;
                        r_state <= S_DISP;
                    end else begin
                        r_state <= S_DR_WR;
                    end
                end
                S_DR_WR: begin
                    r_idx   <= w_idx_inc;
                    r_state <= S_DR_RD;
                end
                S_DISP: begin
                    case (r_ph)
                        P_PRUNE: begin
                            if (r_flag) begin
                                r_idx   <= w_pos_inc;
                                r_ph    <= P_PRUNE_D;
                                r_state <= S_DR_RD;
                            end else if (r_pos != '0) begin
                                r_ci    <= w_pos_dec;
                                r_cj    <= r_pos;
                                r_ph    <= P_LEFT;
                                r_state <= S_CR_START;
                            end else begin
                                r_cur   <= r_pos;
                                r_state <= S_CH_RD;
                            end
                        end
                        P_PRUNE_D: begin
                            r_ci    <= r_pos;
                            r_cj    <= w_pos_inc;
                            r_ph    <= P_PRUNE;
                            r_state <= S_CR_START;
                        end
                        P_LEFT: begin
                            r_cur <= w_pos_dec;
                            if (r_flag) begin
                                r_idx   <= r_pos;
                                r_ph    <= P_LEFT_D;
                                r_state <= S_DR_RD;
                            end else begin
                                r_state <= S_CH_RD;
                            end
                        end
                        P_LEFT_D: begin
                            r_ci    <= r_cur;
                            r_cj    <= r_pos;
                            r_ph    <= P_LEFT_X;
                            r_state <= S_CR_START;
                        end
                        P_LEFT_X: r_state <= S_CH_RD;
                        P_CHAIN_D: begin
                            r_ci    <= w_cur_dec;
                            r_cj    <= r_cur;
                            r_ph    <= P_CHAIN_X;
                            r_state <= S_CR_START;
                        end
                        P_CHAIN_X: begin
                            r_cur   <= w_cur_dec;
                            r_state <= S_CH_RD;
                        end
                        default: r_state <= S_IDLE;
                    endcase
                end
                // Walk left while the left neighbor no longer reaches the envelope.
                S_CH_RD: begin
                    if (r_cur == '0) begin
                        r_stat  <= lhq_pkg::ST_OK;
                        r_state <= S_OUT;
                    end else begin
                        r_state <= S_CH_R2;
                    end
                end
                S_CH_R2: begin
                    r_bpa   <= w_rdata.bp;
                    r_state <= S_CH_CK;
                end
                S_CH_CK: begin
                    if (r_bpa >= w_rdata.bp) begin
                        r_idx   <= r_cur;
                        r_ph    <= P_CHAIN_D;
                        r_state <= S_DR_RD;
                    end else begin
                        r_stat  <= lhq_pkg::ST_OK;
                        r_state <= S_OUT;
                    end
                end
                // Query: first entry whose breakpoint reaches x.
                S_Q_RD: r_state <= S_Q_CK;
                S_Q_CK: begin
                    if ((w_idx_inc < r_cnt) &&
                        (w_rdata.bp < $signed({{32{r_x[31]}}, r_x}))) begin
                        r_idx   <= w_idx_inc;
                        r_state <= S_Q_RD;
                    end else begin
                        r_ei_slope <= w_rdata.slope;
                        r_ei_icpt  <= w_rdata.icpt;
                        r_state    <= S_Q_MUL;
                    end
                end
                S_Q_MUL: begin
                    r_prod  <= w_prod;
                    r_state <= S_Q_ADD;
                end
                S_Q_ADD: begin
                    r_res   <= r_min_mode ? -w_sum : w_sum;
                    r_stat  <= lhq_pkg::ST_OK;
                    r_state <= S_OUT;
                end
                // Hold the result until the response register is free.
                S_OUT: begin
                    if (!r_ov || o_rsp.ready) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Response valid: set when a result moves in, clear when it is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if ((r_state == S_OUT) && (!r_ov || o_rsp.ready)) begin
            r_ov <= 1'b1;
        end else if (o_rsp.ready) begin
            r_ov <= 1'b0;
        end
    end

    // Response register: loaded from the working result when a request ends.
    logic signed [63:0] r_out_val;
    logic [1:0]         r_out_stat;

    always_ff @(posedge i_clk) begin
        if ((r_state == S_OUT) && (!r_ov || o_rsp.ready)) begin
            r_out_val  <= r_res;
            r_out_stat <= r_stat;
        end
    end

    assign i_req.ready      = r_state == S_IDLE;
    assign o_rsp.valid      = r_ov;
    assign o_rsp.best_value = r_out_val;
    assign o_rsp.status     = r_out_stat;

    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt <= CW'(MAX_LINES))
        else $error("line count above capacity");

    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && (r_out_stat != lhq_pkg::ST_OK)) |-> (r_out_val == 64'sd0))
        else $error("error response with nonzero value");

    a_empty_query: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready && (i_req.func == lhq_pkg::FN_QUERY) &&
         (r_cnt == '0)) |=> (r_state == S_OUT) && (r_stat == lhq_pkg::ST_EMPTY))
        else $error("empty query not flagged");

    a_cnt_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $past(i_rst_n) |-> (r_cnt == $past(r_cnt)) ||
        (r_cnt == $past(r_cnt) + 1'b1) || (r_cnt == $past(r_cnt) - 1'b1))
        else $error("line count jumped");

    a_div_wait: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_CR_DIV))
        else $error("divider finished outside its wait step");
endmodule
